// ----- rtl/hpte_pkg.sv -----
// ----------------------------------------------------------------------------
// hpte_pkg
// Types and constants shared by the hashed page table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hpte_pkg;

  localparam int BASE_BITS   = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] REQ_MAP     = 2'd0;
  localparam logic [1:0] REQ_UNMAP   = 2'd1;
  localparam logic [1:0] REQ_INHIBIT = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COPYBACK_ENABLED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COPYBACK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TEXT_END  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SEGMENT   = 3'd4;

  localparam logic [3:0]  KERNEL_SEGMENT_RST = 4'd9;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] vaddr;
    logic [23:0] seg_id;
    logic [19:0] phys_page;
    logic        user_page;
    logic        writable;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       accessed;
    logic       dirty;
  } rsp_t;

  typedef struct packed {
    logic        v;
    logic [23:0] vsid;
    logic        h;
    logic [5:0]  api;
    logic [19:0] rpn;
    logic        r;
    logic        c;
    logic        w;
    logic        i;
    logic        m;
    logic        g;
    logic [1:0]  pp;
  } hpte_t;

endpackage

`default_nettype wire

// ----- rtl/hpte_req_if.sv -----
// ----------------------------------------------------------------------------
// hpte_req_if
// Request channel: valid/ready handshake carrying one request transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpte_req_if;
  import hpte_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/hpte_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hpte_rsp_if
// Response channel: valid/ready handshake carrying one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpte_rsp_if;
  import hpte_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/hashed_page_table_engine_unit.sv -----
// Scan: both groups are scanned, primary then secondary, unless a hit in scan slot k (0..15)
//   ends the scan early; the result is then registered in S_WRITE once the output register is free.
// Flow: one request at a time, none accepted until the last result is registered; the scan reads one
//   entry per cycle from the single-port table (up to 16 reads), then writes back in S_WRITE.
// Reset: synchronous; a clearing pass then writes every entry invalid, one per cycle
//   (all GROUP_WAYS << (10 + MASK_BITS) entries, 16384 by default), with no request taken.
// ----------------------------------------------------------------------------
// hashed_page_table_engine_unit
// Hashed page table with primary/secondary groups: map, unmap, cache inhibit.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_page_table_engine_unit #(
  parameter int MASK_BITS  = 1,
  parameter int GROUP_WAYS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [hpte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hpte_pkg::CFG_DATA_W-1:0] cfg_data,
  hpte_req_if.sink                            req,
  hpte_rsp_if.source                          rsp
);
  import hpte_pkg::*;

  localparam int MW        = (MASK_BITS > 0) ? MASK_BITS : 1;
  localparam int GW        = BASE_BITS + MASK_BITS;
  localparam int WB        = $clog2(GROUP_WAYS);
  localparam int AW        = GW + WB;
  localparam int ENTRIES   = GROUP_WAYS << GW;
  localparam int SW        = WB + 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_WRITE} state_t;

  // configuration
  logic [MW-1:0] tsm;
  logic          copyback_enabled;
  logic          kernel_copyback;
  logic [31:0]   kernel_text_end;
  logic [3:0]    kernel_segment;

  always_ff @(posedge clk) begin
    if (rst) begin
      tsm              <= '0;
      copyback_enabled <= 1'b1;
      kernel_copyback  <= 1'b1;
      kernel_text_end  <= '0;
      kernel_segment   <= KERNEL_SEGMENT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TABLE_SIZE_MASK:  tsm <= (MASK_BITS == 0) ? '0 : cfg_data[MW-1:0];
        CFG_COPYBACK_ENABLED: copyback_enabled <= cfg_data[0];
        CFG_KERNEL_COPYBACK:  kernel_copyback <= cfg_data[0];
        CFG_KERNEL_TEXT_END:  kernel_text_end <= cfg_data[31:0];
        CFG_KERNEL_SEGMENT:   kernel_segment <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // control and request registers
  state_t        state;
  req_t          rq;
  logic [SW:0]   cnt;
  logic          chk_valid;
  logic [SW-1:0] chk_slot;
  logic [AW-1:0] chk_addr;
  logic          hit;
  logic [AW-1:0] hit_addr;
  hpte_t         hit_entry;
  logic          free_found;
  logic [AW-1:0] free_addr;
  logic          free_h;
  logic [AW-1:0] clr_cnt;
  logic          rsp_valid;
  rsp_t          rsp_data;

  // table memory
  hpte_t         mem [0:ENTRIES-1];
  hpte_t         rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  hpte_t         mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // hash and group addresses
  logic [23:0]   hash;
  logic [GW-1:0] idx_mask;
  logic [GW-1:0] grp0;
  logic [GW-1:0] grp1;
  logic [AW-1:0] iss_addr;
  logic [5:0]    api;

  assign api      = rq.vaddr[27:22];
  assign hash     = {8'd0, rq.vaddr[27:12]} ^ rq.seg_id;
  assign idx_mask = GW'(10'h3FF) | (GW'(tsm) << BASE_BITS);
  assign grp0     = hash[GW-1:0] & idx_mask;
  assign grp1     = ~hash[GW-1:0] & idx_mask;
  assign iss_addr = cnt[WB] ? {grp1, cnt[WB-1:0]} : {grp0, cnt[WB-1:0]};

  // scan evaluation
  logic chk_h;
  logic match;
  logic last_chk;

  assign chk_h    = chk_slot[WB];
  assign match    = chk_valid && rd_data.v && (rd_data.vsid == rq.seg_id) &&
                    (rd_data.h == chk_h) && (rd_data.api == api);
  assign last_chk = chk_valid && (&chk_slot);

  // new entry for map
  hpte_t new_entry;
  logic  copyback;

  assign copyback = copyback_enabled &&
                    (kernel_copyback || rq.user_page || (rq.vaddr < kernel_text_end));

  always_comb begin
    new_entry      = '0;
    new_entry.v    = 1'b1;
    new_entry.vsid = rq.seg_id;
    new_entry.h    = hit ? hit_entry.h : free_h;
    new_entry.api  = api;
    new_entry.rpn  = (rq.phys_page[19:16] == kernel_segment) ?
                     {4'd0, rq.phys_page[15:0]} : rq.phys_page;
    new_entry.w    = !copyback;
    new_entry.m    = copyback;
    new_entry.pp   = rq.user_page ? (rq.writable ? 2'd2 : 2'd3) : 2'd0;
  end

  // write-back decision
  logic  out_free;
  logic  wb_we;
  logic [AW-1:0] wb_addr;
  hpte_t wb_data;
  rsp_t  wb_rsp;

  assign out_free = !rsp_valid || rsp.ready;

  always_comb begin
    wb_we          = 1'b0;
    wb_addr        = hit_addr;
    wb_data        = hit_entry;
    wb_rsp         = '0;
    wb_rsp.status  = ST_NOT_FOUND;
    unique case (rq.req_type)
      REQ_MAP: begin
        wb_data = new_entry;
        if (hit) begin
          wb_we         = 1'b1;
          wb_rsp.status = ST_DONE;
        end else if (free_found) begin
          wb_we         = 1'b1;
          wb_addr       = free_addr;
          wb_rsp.status = ST_DONE;
        end else begin
          wb_rsp.status = ST_FULL;
        end
      end
      REQ_UNMAP: begin
        if (hit) begin
          wb_we           = 1'b1;
          wb_data.v       = 1'b0;
          wb_rsp.status   = ST_DONE;
          wb_rsp.accessed = hit_entry.r;
          wb_rsp.dirty    = hit_entry.c;
        end
      end
      REQ_INHIBIT: begin
        if (hit) begin
          wb_we         = 1'b1;
          wb_data.i     = 1'b1;
          wb_data.m     = 1'b0;
          wb_rsp.status = ST_DONE;
        end
      end
      default: ;
    endcase
  end

  // memory port select
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = iss_addr;
    mem_wdata = wb_data;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = '0;
      end
      S_WRITE: begin
        mem_we   = wb_we && out_free;
        mem_addr = wb_addr;
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      cnt        <= '0;
      chk_valid  <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if ((state == S_WRITE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            rq         <= req.data;
            cnt        <= '0;
            chk_valid  <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            hit       <= 1'b1;
            hit_addr  <= chk_addr;
            hit_entry <= rd_data;
          end else if (chk_valid && !rd_data.v && !free_found) begin
            free_found <= 1'b1;
            free_addr  <= chk_addr;
            free_h     <= chk_h;
          end
          if (!cnt[SW]) begin
            chk_valid <= 1'b1;
            chk_slot  <= cnt[SW-1:0];
            chk_addr  <= iss_addr;
            cnt       <= cnt + 1'b1;
          end else begin
            chk_valid <= 1'b0;
          end
          if (match || last_chk) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            rsp_data  <= wb_rsp;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
